// ===== design/mvf_pkg.sv =====
package mvf_pkg;

  // Field widths of the command and result items.
  localparam int CMD_W   = 3;
  localparam int CH_W    = 4;
  localparam int VOL_W   = 16;
  localparam int FRAME_W = 16;
  localparam int PROD_W  = VOL_W + FRAME_W;

  // Default channel count and the unity gain level in Q2.14.
  localparam int CHANNELS_DEFAULT = 11;
  localparam logic [VOL_W-1:0] UNITY_LEVEL = 16'd16384;

  // Depth of the command queue and of the result queue.
  localparam int QUEUE_DEPTH = 2;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_TICK        = 3'd0;
  localparam logic [CMD_W-1:0] CMD_CHANGE_ONE  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CHANGE_PAIR = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CHANGE_ALL  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_QUERY       = 3'd4;

  // Result kinds.
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Operation handed from the front end to the engine.
  typedef enum logic [1:0] {
    OP_TICK,
    OP_CHANGE,
    OP_QUERY
  } op_t;

  // One decoded job: an operation over a range of channels.
  typedef struct packed {
    op_t                op;
    logic [CH_W-1:0]    ch_first;
    logic [CH_W-1:0]    ch_final;
    logic               ch_valid;
    logic [VOL_W-1:0]   target;
    logic [FRAME_W-1:0] frames;
  } job_t;

  // One result item.
  typedef struct packed {
    logic             kind;
    logic [CH_W-1:0]  channel;
    logic [VOL_W-1:0] volume;
    logic             fading;
    logic             last;
  } result_t;

  // Divider status seen by the engine.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ===== design/mvf_front.sv =====
module mvf_front #(
  parameter int CHANNELS = mvf_pkg::CHANNELS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [mvf_pkg::CMD_W-1:0]   command,
  input  logic [mvf_pkg::CH_W-1:0]    channel,
  input  logic [mvf_pkg::VOL_W-1:0]   target_volume,
  input  logic [mvf_pkg::FRAME_W-1:0] frame_count,
  output logic                        job_valid,
  input  logic                        job_ready,
  output mvf_pkg::job_t               job
);

  localparam int PTR_W = $clog2(mvf_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(mvf_pkg::QUEUE_DEPTH + 1);

  mvf_pkg::job_t    queue [mvf_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  mvf_pkg::job_t decoded;
  logic          keep;
  logic          ch_in_range;
  logic          store;
  logic          take;

  assign ch_in_range = ({1'b0, channel} < (mvf_pkg::CH_W + 1)'(CHANNELS));

  // Classify the item; items that cause nothing are accepted and dropped here.
  always_comb begin
    decoded.op       = mvf_pkg::OP_TICK;
    decoded.ch_first = '0;
    decoded.ch_final = mvf_pkg::CH_W'(CHANNELS - 1);
    decoded.ch_valid = 1'b1;
    decoded.target   = target_volume;
    decoded.frames   = frame_count;
    keep             = 1'b1;
    unique case (command)
      mvf_pkg::CMD_TICK: begin
        decoded.op = mvf_pkg::OP_TICK;
      end
      mvf_pkg::CMD_CHANGE_ONE: begin
        decoded.op       = mvf_pkg::OP_CHANGE;
        decoded.ch_first = channel;
        decoded.ch_final = channel;
        keep             = ch_in_range;
      end
      mvf_pkg::CMD_CHANGE_PAIR: begin
        decoded.op       = mvf_pkg::OP_CHANGE;
        decoded.ch_final = mvf_pkg::CH_W'(1);
      end
      mvf_pkg::CMD_CHANGE_ALL: begin
        decoded.op = mvf_pkg::OP_CHANGE;
      end
      mvf_pkg::CMD_QUERY: begin
        decoded.op       = mvf_pkg::OP_QUERY;
        decoded.ch_first = channel;
        decoded.ch_final = channel;
        decoded.ch_valid = ch_in_range;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign full      = (count == CNT_W'(mvf_pkg::QUEUE_DEPTH));
  assign store     = push && !full && keep;
  assign job_valid = (count != '0);
  assign take      = job_valid && job_ready;
  assign job       = queue[rd_ptr];

  // Short job queue between the front end and the engine.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (store) begin
        queue[wr_ptr] <= decoded;
        wr_ptr        <= wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (store && !take) begin
        count <= count + 1'b1;
      end else if (take && !store) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== design/mvf_divider.sv =====
module mvf_divider (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [mvf_pkg::PROD_W-1:0]  dividend,
  input  logic [mvf_pkg::FRAME_W-1:0] divisor,
  output logic [mvf_pkg::VOL_W-1:0]   quotient,
  output mvf_pkg::div_status_t        status
);

  // The quotient is known to fit the volume width, so only that many steps run.
  localparam int STEPS = mvf_pkg::VOL_W;
  localparam int CNT_W = $clog2(STEPS);

  logic                        busy;
  logic                        done;
  logic [CNT_W-1:0]            cnt;
  logic [mvf_pkg::FRAME_W-1:0] rem;
  logic [mvf_pkg::VOL_W-1:0]   low_bits;
  logic [mvf_pkg::VOL_W-1:0]   quo;

  logic [mvf_pkg::FRAME_W:0]   shifted;
  logic                        fits;
  logic [mvf_pkg::FRAME_W:0]   reduced;

  // One restoring step: bring down a bit, subtract the divisor if it fits.
  assign shifted = {rem, low_bits[mvf_pkg::VOL_W-1]};
  assign fits    = (shifted >= {1'b0, divisor});
  assign reduced = fits ? (shifted - {1'b0, divisor}) : shifted;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy     <= 1'b1;
        cnt      <= '0;
        rem      <= dividend[mvf_pkg::PROD_W-1:mvf_pkg::VOL_W];
        low_bits <= dividend[mvf_pkg::VOL_W-1:0];
      end else if (busy) begin
        rem      <= reduced[mvf_pkg::FRAME_W-1:0];
        low_bits <= {low_bits[mvf_pkg::VOL_W-2:0], 1'b0};
        quo      <= {quo[mvf_pkg::VOL_W-2:0], fits};
        cnt      <= cnt + 1'b1;
        if (cnt == CNT_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient    = quo;
  assign status.busy = busy;
  assign status.done = done;

endmodule

// ===== design/mvf_engine.sv =====
module mvf_engine #(
  parameter int CHANNELS = mvf_pkg::CHANNELS_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            job_valid,
  output logic            job_ready,
  input  mvf_pkg::job_t   job,
  output logic            out_push,
  input  logic            out_full,
  output mvf_pkg::result_t out_item
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_VISIT,
    S_MUL,
    S_DIVGO,
    S_DIV,
    S_WRITE,
    S_QUERY,
    S_FLUSH
  } state_t;

  state_t state;

  // Per-channel fade state.
  logic                        running       [CHANNELS];
  logic [mvf_pkg::FRAME_W-1:0] frame_counter [CHANNELS];
  logic [mvf_pkg::FRAME_W-1:0] fade_length   [CHANNELS];
  logic [mvf_pkg::VOL_W-1:0]   start_level   [CHANNELS];
  logic [mvf_pkg::VOL_W-1:0]   end_level     [CHANNELS];
  logic [mvf_pkg::VOL_W-1:0]   current_level [CHANNELS];

  mvf_pkg::job_t               cur;
  logic [mvf_pkg::CH_W-1:0]    idx;
  logic [mvf_pkg::PROD_W-1:0]  prod;
  logic                        neg;
  logic [mvf_pkg::VOL_W-1:0]   base;
  mvf_pkg::result_t            pend;
  logic                        pend_valid;

  logic                        div_start;
  logic [mvf_pkg::VOL_W-1:0]   quot;
  mvf_pkg::div_status_t        div_stat;

  logic                        at_final;
  logic                        immediate;
  logic                        can_emit;
  logic                        want_emit;
  logic                        fire;
  mvf_pkg::result_t            new_res;
  logic [mvf_pkg::VOL_W-1:0]   mag;
  logic [mvf_pkg::FRAME_W-1:0] fc_inc;
  logic [mvf_pkg::VOL_W-1:0]   level_new;
  logic                        still_running;

  mvf_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (fade_length[idx]),
    .quotient (quot),
    .status   (div_stat)
  );

  assign job_ready     = (state == S_IDLE);
  assign at_final      = (idx == cur.ch_final);
  assign immediate     = (cur.frames == '0);
  assign div_start     = (state == S_DIVGO);
  assign mag           = (end_level[idx] >= start_level[idx]) ?
                         (end_level[idx] - start_level[idx]) :
                         (start_level[idx] - end_level[idx]);
  assign fc_inc        = frame_counter[idx] + 1'b1;
  assign level_new     = neg ? (base - quot) : (base + quot);
  assign still_running = (frame_counter[idx] < fade_length[idx]);

  // Build the result of the current step.
  always_comb begin
    new_res        = '0;
    new_res.kind   = mvf_pkg::KIND_WRITE;
    new_res.channel = idx;
    want_emit      = 1'b0;
    case (state)
      S_VISIT: begin
        new_res.volume = cur.target;
        want_emit      = (cur.op == mvf_pkg::OP_CHANGE) && immediate;
      end
      S_WRITE: begin
        new_res.volume = level_new;
        new_res.fading = still_running;
        want_emit      = 1'b1;
      end
      S_QUERY: begin
        new_res.kind   = mvf_pkg::KIND_QUERY;
        new_res.volume = cur.ch_valid ? current_level[idx] : '0;
        new_res.fading = cur.ch_valid ? running[idx] : 1'b0;
        want_emit      = 1'b1;
      end
      default: begin
        want_emit = 1'b0;
      end
    endcase
  end

  // A new result goes into the hold slot; the older one leaves not yet marked last.
  assign can_emit = !pend_valid || !out_full;
  assign fire     = want_emit && can_emit;
  assign out_push = (fire && pend_valid) ||
                    ((state == S_FLUSH) && pend_valid && !out_full);

  always_comb begin
    out_item      = pend;
    out_item.last = (state == S_FLUSH);
  end

  // Sequencer over the channels of one job, with the fade state it updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pend_valid <= 1'b0;
      idx        <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        running[i]       <= 1'b0;
        frame_counter[i] <= '0;
        fade_length[i]   <= '0;
        start_level[i]   <= '0;
        end_level[i]     <= '0;
        current_level[i] <= mvf_pkg::UNITY_LEVEL;
      end
    end else begin
      if (fire) begin
        pend       <= new_res;
        pend_valid <= 1'b1;
      end else if ((state == S_FLUSH) && !out_full) begin
        pend_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (job_valid) begin
            cur   <= job;
            idx   <= job.ch_first;
            state <= (job.op == mvf_pkg::OP_QUERY) ? S_QUERY : S_VISIT;
          end
        end
        S_VISIT: begin
          if (cur.op == mvf_pkg::OP_CHANGE) begin
            if (immediate) begin
              if (fire) begin
                current_level[idx] <= cur.target;
                running[idx]       <= 1'b0;
                state              <= at_final ? S_FLUSH : S_VISIT;
                idx                <= at_final ? idx : idx + 1'b1;
              end
            end else begin
              running[idx]       <= 1'b1;
              frame_counter[idx] <= '0;
              fade_length[idx]   <= cur.frames;
              start_level[idx]   <= current_level[idx];
              end_level[idx]     <= cur.target;
              state              <= at_final ? S_FLUSH : S_VISIT;
              idx                <= at_final ? idx : idx + 1'b1;
            end
          end else if (running[idx] && still_running) begin
            state <= S_MUL;
          end else begin
            running[idx] <= 1'b0;
            state        <= at_final ? S_FLUSH : S_VISIT;
            idx          <= at_final ? idx : idx + 1'b1;
          end
        end
        S_MUL: begin
          prod               <= mag * fc_inc;
          neg                <= (end_level[idx] < start_level[idx]);
          base               <= start_level[idx];
          frame_counter[idx] <= fc_inc;
          state              <= S_DIVGO;
        end
        S_DIVGO: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_stat.done) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (fire) begin
            current_level[idx] <= level_new;
            running[idx]       <= still_running;
            state              <= at_final ? S_FLUSH : S_VISIT;
            idx                <= at_final ? idx : idx + 1'b1;
          end
        end
        S_QUERY: begin
          if (fire) begin
            state <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          if (!pend_valid || !out_full) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The result queue is never written while it is full.
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    out_push |-> !out_full)
    else $error("result pushed into a full queue");

  // The divider is only started while it is idle.
  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  // A job is only taken once the previous result has left with its last mark.
  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !pend_valid)
    else $error("result held while idle");

  // Leaving the flush state always drains the hold slot.
  a_flush_drains: assert property (@(posedge clk) disable iff (rst)
    ((state == S_FLUSH) && pend_valid && !out_full) |-> out_push && out_item.last)
    else $error("final result not marked last");

endmodule

// ===== design/mvf_out_queue.sv =====
module mvf_out_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  mvf_pkg::result_t item,
  input  logic             pop,
  output logic             empty,
  output mvf_pkg::result_t head
);

  localparam int PTR_W = $clog2(mvf_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(mvf_pkg::QUEUE_DEPTH + 1);

  mvf_pkg::result_t queue [mvf_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             put;
  logic             take;

  assign full  = (count == CNT_W'(mvf_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign put   = push && !full;
  assign take  = pop && !empty;
  assign head  = queue[rd_ptr];

  // Small result queue so the engine keeps working while a result waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (put) begin
        queue[wr_ptr] <= item;
        wr_ptr        <= wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (put && !take) begin
        count <= count + 1'b1;
      end else if (take && !put) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== design/multichannel_volume_fade.sv =====
// A query's reply passes the engine's hold slot into the result queue.
// A change item visits each affected channel in turn.
// A tick visits every channel in turn, and each running fade also passes
// through the shared multiplier and the 16-step restoring divider.
// Commands are queued two deep, so new items are taken while the engine works.
// Synchronous reset: all fades stop and every channel returns to unity gain.
module multichannel_volume_fade #(
  parameter int CHANNELS = mvf_pkg::CHANNELS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [mvf_pkg::CMD_W-1:0]   command,
  input  logic [mvf_pkg::CH_W-1:0]    channel,
  input  logic [mvf_pkg::VOL_W-1:0]   target_volume,
  input  logic [mvf_pkg::FRAME_W-1:0] frame_count,
  output logic                        empty,
  input  logic                        pop,
  output logic                        kind,
  output logic [mvf_pkg::CH_W-1:0]    out_channel,
  output logic [mvf_pkg::VOL_W-1:0]   volume,
  output logic                        fading,
  output logic                        last
);

  logic             job_valid;
  logic             job_ready;
  mvf_pkg::job_t    job;
  logic             res_push;
  logic             res_full;
  mvf_pkg::result_t res_item;
  mvf_pkg::result_t res_head;

  mvf_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .command       (command),
    .channel       (channel),
    .target_volume (target_volume),
    .frame_count   (frame_count),
    .job_valid     (job_valid),
    .job_ready     (job_ready),
    .job           (job)
  );

  mvf_engine #(
    .CHANNELS (CHANNELS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job),
    .out_push  (res_push),
    .out_full  (res_full),
    .out_item  (res_item)
  );

  mvf_out_queue u_out (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .full  (res_full),
    .item  (res_item),
    .pop   (pop),
    .empty (empty),
    .head  (res_head)
  );

  // Split the oldest result into its fields.
  assign kind        = res_head.kind;
  assign out_channel = res_head.channel;
  assign volume      = res_head.volume;
  assign fading      = res_head.fading;
  assign last        = res_head.last;

endmodule
